// File: rtl/psot_pkg.sv
// Shared constants and types for the point set overlap test block.
package psot_pkg;

    localparam int MAX_POINTS = 512;
    localparam int COORD_BITS = 24;
    localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int ROW_W      = 3 * COORD_BITS;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int RADIUS_W   = 48;
    localparam int RATIO_W    = 16;
    localparam int CMP_W      = (SUM_W > RADIUS_W) ? SUM_W : RADIUS_W;
    localparam int PROD_W     = RATIO_W + CNT_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 48;

    localparam logic [RADIUS_W-1:0]  RADIUS_RESET = 48'd94249;
    localparam logic [RATIO_W-1:0]   RATIO_RESET  = 16'd52429;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO  = 1'b1;

    localparam logic REQ_SET_A = 1'b0;
    localparam logic REQ_SET_B = 1'b1;

    typedef logic [ROW_W-1:0] t_row;

    // status returned by the distance unit
    typedef struct packed {
        logic done;
        logic hit;
    } t_dist_res;

endpackage

// File: rtl/psot_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
module psot_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/psot_dist.sv
// Shared distance unit: one squarer, three coordinates per point pair.
module psot_dist (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  psot_pkg::t_row                      i_probe,
    input  psot_pkg::t_row                      i_ref,
    input  logic [psot_pkg::RADIUS_W-1:0]       i_radius,
    output psot_pkg::t_dist_res                 o_res
);

    psot_pkg::t_row                        r_p;
    psot_pkg::t_row                        r_q;
    logic [1:0]                            r_k;
    logic                                  r_run;
    logic [psot_pkg::DIFF_W-1:0]           r_diff;
    logic                                  r_dv;
    logic                                  r_dlast;
    logic [psot_pkg::SQ_W-1:0]             r_sq;
    logic                                  r_sv;
    logic                                  r_slast;
    logic [psot_pkg::SUM_W-1:0]            r_sum;
    logic                                  r_done;
    logic                                  r_hit;

    logic signed [psot_pkg::COORD_BITS-1:0] s_pc;
    logic signed [psot_pkg::COORD_BITS-1:0] s_qc;
    logic signed [psot_pkg::DIFF_W-1:0]     s_diff;
    logic [psot_pkg::DIFF_W-1:0]            s_abs;
    logic [psot_pkg::SUM_W-1:0]             n_sum;
    logic                                   s_hit;

    // coordinate select: x, y, z from the top of the row down
    always_comb begin
        case (r_k)
            2'd0: begin
                s_pc = r_p[3*psot_pkg::COORD_BITS-1 -: psot_pkg::COORD_BITS];
                s_qc = r_q[3*psot_pkg::COORD_BITS-1 -: psot_pkg::COORD_BITS];
            end
            2'd1: begin
                s_pc = r_p[2*psot_pkg::COORD_BITS-1 -: psot_pkg::COORD_BITS];
                s_qc = r_q[2*psot_pkg::COORD_BITS-1 -: psot_pkg::COORD_BITS];
            end
            default: begin
                s_pc = r_p[psot_pkg::COORD_BITS-1:0];
                s_qc = r_q[psot_pkg::COORD_BITS-1:0];
            end
        endcase
    end

    assign s_diff = {s_pc[psot_pkg::COORD_BITS-1], s_pc} - {s_qc[psot_pkg::COORD_BITS-1], s_qc};
    assign s_abs  = s_diff[psot_pkg::DIFF_W-1] ? psot_pkg::DIFF_W'(-s_diff)
                                               : psot_pkg::DIFF_W'(s_diff);
    assign n_sum  = r_sum + psot_pkg::SUM_W'(r_sq);
    assign s_hit  = psot_pkg::CMP_W'(n_sum) <= psot_pkg::CMP_W'(i_radius);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_dv   <= 1'b0;
            r_sv   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            // stage 1: absolute difference
            r_diff  <= s_abs;
            r_dv    <= r_run;
            r_dlast <= (r_k == 2'd2);
            // stage 2: square
            r_sq    <= psot_pkg::SQ_W'(r_diff) * psot_pkg::SQ_W'(r_diff);
            r_sv    <= r_dv;
            r_slast <= r_dlast;
            // stage 3: accumulate, compare on the last term
            r_done  <= 1'b0;
            if (r_sv) begin
                r_sum <= n_sum;
                if (r_slast) begin
                    r_done <= 1'b1;
                    r_hit  <= s_hit;
                end
            end
            if (i_start) begin
                r_p   <= i_probe;
                r_q   <= i_ref;
                r_k   <= 2'd0;
                r_run <= 1'b1;
                r_sum <= '0;
            end else if (r_run) begin
                r_k <= r_k + 2'd1;
                if (r_k == 2'd2) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.hit  = r_hit;

endmodule

// File: rtl/point_set_overlap_test.sv
// Point set overlap test: top level with loader, pair sequencer and ratio check.
//
// Requests carry one 3-D point each (signed coordinates, 1/1024 m per unit) and
// append it to set A (req_type 0) or set B (req_type 1); a request is taken
// when start is high and busy is low, one per cycle while loading. Each set
// holds 512 points; a point aimed at a full set is dropped and the round's
// overflow flag is raised. A request with last set is appended like any other
// and then starts the search: busy goes high, the larger set becomes the
// reference (B on a tie) and every probe point is checked against reference
// points, in order, until the first one within the configured squared radius.
// Point pairs go one at a time through the single shared squarer, which walks
// the three coordinates of a pair through a difference / square / accumulate
// pipeline before the compare. A round's run time grows with the number of
// reference points visited for each probe point; an empty probe set skips the
// search. The result (overlapped, matched and probe counts, overflow) is
// shown for exactly one cycle with o_valid and cannot be held off; busy drops
// in that same cycle and the next round may begin loading at once. Both
// registers (radius squared, minimum ratio in Q0.16) are written through the
// plain write port and should only be changed while busy is low. Nothing in
// the point stores is cleared at reset; only entries already loaded are read.
module point_set_overlap_test (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_req_type,
    input  logic signed [psot_pkg::COORD_BITS-1:0] i_x_coord,
    input  logic signed [psot_pkg::COORD_BITS-1:0] i_y_coord,
    input  logic signed [psot_pkg::COORD_BITS-1:0] i_z_coord,
    input  logic                                   i_last,
    input  logic                                   i_cfg_we,
    input  logic [psot_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [psot_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    output logic                                   o_valid,
    output logic                                   o_overlapped,
    output logic [psot_pkg::CNT_W-1:0]             o_matched_count,
    output logic [psot_pkg::CNT_W-1:0]             o_probe_count,
    output logic                                   o_overflow
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_SETUP,
        S_PAIR_RD,
        S_PAIR_GO,
        S_PAIR_WAIT,
        S_RATIO,
        S_OUT
    } t_state;

    t_state                               r_state;
    logic [psot_pkg::CNT_W-1:0]           r_a_cnt;
    logic [psot_pkg::CNT_W-1:0]           r_b_cnt;
    logic                                 r_drop;
    logic [psot_pkg::RADIUS_W-1:0]        r_radius;
    logic [psot_pkg::RATIO_W-1:0]         r_ratio;
    logic                                 r_sel_a_ref;   // set A is the reference
    logic [psot_pkg::CNT_W-1:0]           r_probe_n;
    logic [psot_pkg::CNT_W-1:0]           r_ref_n;
    logic [psot_pkg::CNT_W-1:0]           r_i;
    logic [psot_pkg::CNT_W-1:0]           r_j;
    logic [psot_pkg::CNT_W-1:0]           r_match;
    logic [psot_pkg::PROD_W-1:0]          r_prod;
    logic                                 r_valid;
    logic                                 r_over;
    logic [psot_pkg::CNT_W-1:0]           r_mcnt;
    logic [psot_pkg::CNT_W-1:0]           r_pcnt;
    logic                                 r_ovf;

    logic                                 s_accept;
    logic                                 s_a_room;
    logic                                 s_b_room;
    logic                                 s_we_a;
    logic                                 s_we_b;
    logic                                 s_sel;
    psot_pkg::t_row                       s_wrow;
    logic [psot_pkg::ADDR_W-1:0]          s_a_raddr;
    logic [psot_pkg::ADDR_W-1:0]          s_b_raddr;
    psot_pkg::t_row                       s_a_rdata;
    psot_pkg::t_row                       s_b_rdata;
    psot_pkg::t_row                       s_probe_row;
    psot_pkg::t_row                       s_ref_row;
    psot_pkg::t_dist_res                  s_res;
    logic [psot_pkg::CNT_W-1:0]           s_i_next;
    logic [psot_pkg::CNT_W-1:0]           s_j_next;
    logic [psot_pkg::PROD_W-1:0]          s_scaled;

    assign busy     = (r_state != S_LOAD);
    assign s_accept = start && !busy;
    assign s_a_room = r_a_cnt < psot_pkg::CNT_W'(psot_pkg::MAX_POINTS);
    assign s_b_room = r_b_cnt < psot_pkg::CNT_W'(psot_pkg::MAX_POINTS);
    assign s_we_a   = s_accept && (i_req_type == psot_pkg::REQ_SET_A) && s_a_room;
    assign s_we_b   = s_accept && (i_req_type == psot_pkg::REQ_SET_B) && s_b_room;
    assign s_sel    = r_a_cnt > r_b_cnt;
    assign s_wrow   = {i_x_coord, i_y_coord, i_z_coord};

    // probe set read at r_i, reference set at r_j
    assign s_a_raddr   = r_sel_a_ref ? r_j[psot_pkg::ADDR_W-1:0] : r_i[psot_pkg::ADDR_W-1:0];
    assign s_b_raddr   = r_sel_a_ref ? r_i[psot_pkg::ADDR_W-1:0] : r_j[psot_pkg::ADDR_W-1:0];
    assign s_probe_row = r_sel_a_ref ? s_b_rdata : s_a_rdata;
    assign s_ref_row   = r_sel_a_ref ? s_a_rdata : s_b_rdata;

    assign s_i_next = r_i + psot_pkg::CNT_W'(1);
    assign s_j_next = r_j + psot_pkg::CNT_W'(1);
    assign s_scaled = {r_match, psot_pkg::RATIO_W'(0)};

    psot_ram #(
        .WIDTH (psot_pkg::ROW_W),
        .DEPTH (psot_pkg::MAX_POINTS)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (s_we_a),
        .i_waddr (r_a_cnt[psot_pkg::ADDR_W-1:0]),
        .i_wdata (s_wrow),
        .i_raddr (s_a_raddr),
        .o_rdata (s_a_rdata)
    );

    psot_ram #(
        .WIDTH (psot_pkg::ROW_W),
        .DEPTH (psot_pkg::MAX_POINTS)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (s_we_b),
        .i_waddr (r_b_cnt[psot_pkg::ADDR_W-1:0]),
        .i_wdata (s_wrow),
        .i_raddr (s_b_raddr),
        .o_rdata (s_b_rdata)
    );

    psot_dist u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_PAIR_GO),
        .i_probe  (s_probe_row),
        .i_ref    (s_ref_row),
        .i_radius (r_radius),
        .o_res    (s_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_a_cnt  <= '0;
            r_b_cnt  <= '0;
            r_drop   <= 1'b0;
            r_radius <= psot_pkg::RADIUS_RESET;
            r_ratio  <= psot_pkg::RATIO_RESET;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= 1'b0;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    psot_pkg::REG_RADIUS: r_radius <= i_cfg_data[psot_pkg::RADIUS_W-1:0];
                    psot_pkg::REG_RATIO:  r_ratio  <= i_cfg_data[psot_pkg::RATIO_W-1:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_LOAD: begin
                    if (s_accept) begin
                        if (s_we_a) begin
                            r_a_cnt <= r_a_cnt + psot_pkg::CNT_W'(1);
                        end else if (s_we_b) begin
                            r_b_cnt <= r_b_cnt + psot_pkg::CNT_W'(1);
                        end else begin
                            r_drop <= 1'b1;   // target set full
                        end
                        if (i_last) begin
                            r_state <= S_SETUP;
                        end
                    end
                end
                S_SETUP: begin
                    r_sel_a_ref <= s_sel;
                    r_probe_n   <= s_sel ? r_b_cnt : r_a_cnt;
                    r_ref_n     <= s_sel ? r_a_cnt : r_b_cnt;
                    r_i         <= '0;
                    r_j         <= '0;
                    r_match     <= '0;
                    // empty probe set skips the search
                    if ((s_sel ? r_b_cnt : r_a_cnt) == '0) begin
                        r_state <= S_RATIO;
                    end else begin
                        r_state <= S_PAIR_RD;
                    end
                end
                S_PAIR_RD: begin
                    r_state <= S_PAIR_GO;
                end
                S_PAIR_GO: begin
                    r_state <= S_PAIR_WAIT;
                end
                S_PAIR_WAIT: begin
                    if (s_res.done) begin
                        if (s_res.hit || (s_j_next == r_ref_n)) begin
                            // done with this probe point
                            if (s_res.hit) begin
                                r_match <= r_match + psot_pkg::CNT_W'(1);
                            end
                            r_i <= s_i_next;
                            r_j <= '0;
                            r_state <= (s_i_next == r_probe_n) ? S_RATIO : S_PAIR_RD;
                        end else begin
                            r_j     <= s_j_next;
                            r_state <= S_PAIR_RD;
                        end
                    end
                end
                S_RATIO: begin
                    r_prod  <= psot_pkg::PROD_W'(r_ratio) * psot_pkg::PROD_W'(r_probe_n);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_over  <= s_scaled > r_prod;
                    r_mcnt  <= r_match;
                    r_pcnt  <= r_probe_n;
                    r_ovf   <= r_drop;
                    r_a_cnt <= '0;
                    r_b_cnt <= '0;
                    r_drop  <= 1'b0;
                    r_state <= S_LOAD;
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_valid         = r_valid;
    assign o_overlapped    = r_over;
    assign o_matched_count = r_mcnt;
    assign o_probe_count   = r_pcnt;
    assign o_overflow      = r_ovf;

`ifndef SYNTHESIS
    a_match_le_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_matched_count <= o_probe_count))
        else $error("matched count above probe count");

    a_overlap_needs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overlapped) |-> (o_matched_count != '0))
        else $error("overlap reported with no matches");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_cnt <= psot_pkg::CNT_W'(psot_pkg::MAX_POINTS))
        && (r_b_cnt <= psot_pkg::CNT_W'(psot_pkg::MAX_POINTS)))
        else $error("set count beyond capacity");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAIR_WAIT) |-> ((r_i < r_probe_n) && (r_j < r_ref_n)))
        else $error("pair index out of range");

    a_result_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while still busy");
`endif

endmodule

// File: bench/tb_point_set_overlap_test.sv
// Self-checking testbench for the point set overlap test block.
module tb_point_set_overlap_test;

    // One stored point, coordinates kept as raw two's complement bits.
    typedef struct packed {
        logic [psot_pkg::COORD_BITS-1:0] x;
        logic [psot_pkg::COORD_BITS-1:0] y;
        logic [psot_pkg::COORD_BITS-1:0] z;
    } t_point;

    // One point request waiting in the driver queue; gap = idle cycles before it.
    typedef struct {
        logic   req_type;
        t_point pt;
        logic   last;
        int     gap;
    } t_point_req;

    // What one round must report.
    typedef struct packed {
        logic                       overlapped;
        logic [psot_pkg::CNT_W-1:0] matched;
        logic [psot_pkg::CNT_W-1:0] probe;
        logic                       overflow;
    } t_verdict;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                                   i_clk      = 1'b0;
    logic                                   i_rst_n    = 1'b0;
    logic                                   start      = 1'b0;
    logic                                   busy;
    logic                                   i_req_type = 1'b0;
    logic signed [psot_pkg::COORD_BITS-1:0] i_x_coord  = '0;
    logic signed [psot_pkg::COORD_BITS-1:0] i_y_coord  = '0;
    logic signed [psot_pkg::COORD_BITS-1:0] i_z_coord  = '0;
    logic                                   i_last     = 1'b0;
    logic                                   i_cfg_we   = 1'b0;
    logic [psot_pkg::CFG_IDX_W-1:0]         i_cfg_idx  = '0;
    logic [psot_pkg::CFG_DATA_W-1:0]        i_cfg_data = '0;
    logic                                   o_valid;
    logic                                   o_overlapped;
    logic [psot_pkg::CNT_W-1:0]             o_matched_count;
    logic [psot_pkg::CNT_W-1:0]             o_probe_count;
    logic                                   o_overflow;

    point_set_overlap_test i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_x_coord       (i_x_coord),
        .i_y_coord       (i_y_coord),
        .i_z_coord       (i_z_coord),
        .i_last          (i_last),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_overlapped    (o_overlapped),
        .o_matched_count (o_matched_count),
        .o_probe_count   (o_probe_count),
        .o_overflow      (o_overflow)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the block: both point stores, fill levels, drop flag
    // and the two registers. Updated when a request is taken.
    // ------------------------------------------------------------------
    t_point                        set_a_pts [psot_pkg::MAX_POINTS];
    t_point                        set_b_pts [psot_pkg::MAX_POINTS];
    int                            a_fill     = 0;
    int                            b_fill     = 0;
    bit                            drop_seen  = 1'b0;
    logic [psot_pkg::RADIUS_W-1:0] radius_cfg = psot_pkg::RADIUS_RESET;
    logic [psot_pkg::RATIO_W-1:0]  ratio_cfg  = psot_pkg::RATIO_RESET;

    t_verdict   verdicts_due [$];   // oldest first
    t_point_req pending_pts [$];    // filled by the sequencer, drained by the driver

    int   pts_queued    = 0;
    int   pts_taken     = 0;
    int   fail_cnt      = 0;
    int   rounds_seen   = 0;
    int   overlap_seen  = 0;
    int   drop_rounds   = 0;
    logic req_taken     = 1'b0;   // request accepted at the last rising edge
    int   idle_run      = 0;
    logic start_nx;
    logic [95:0] junk;
    t_point_req  drv_req;

    // Squared distance of two points against the radius; wide enough that
    // the sum of three 48-bit squares never wraps.
    function automatic bit within_reach(t_point p, t_point q);
        longint dx, dy, dz, sq_sum;
        dx     = longint'($signed(p.x)) - longint'($signed(q.x));
        dy     = longint'($signed(p.y)) - longint'($signed(q.y));
        dz     = longint'($signed(p.z)) - longint'($signed(q.z));
        sq_sum = dx * dx + dy * dy + dz * dz;
        return sq_sum <= longint'(radius_cfg);
    endfunction

    // Exhaustive search over the current round. Larger set is the reference,
    // set B wins a tie so set A is probed then.
    function automatic t_verdict score_round();
        t_verdict v;
        int     probe_n, ref_n, hits, j;
        bit     a_probe, found;
        t_point p, q;
        a_probe = (a_fill <= b_fill);
        probe_n = a_probe ? a_fill : b_fill;
        ref_n   = a_probe ? b_fill : a_fill;
        hits    = 0;
        for (int i = 0; i < probe_n; i++) begin
            p     = a_probe ? set_a_pts[i] : set_b_pts[i];
            found = 1'b0;
            for (j = 0; j < ref_n && !found; j++) begin
                q     = a_probe ? set_b_pts[j] : set_a_pts[j];
                found = within_reach(p, q);
            end
            if (found)
                hits++;
        end
        // strict compare: matched / probe must exceed ratio / 65536
        v.overlapped = (longint'(hits) << 16) > (longint'(ratio_cfg) * longint'(probe_n));
        v.matched    = hits[psot_pkg::CNT_W-1:0];
        v.probe      = probe_n[psot_pkg::CNT_W-1:0];
        v.overflow   = drop_seen;
        return v;
    endfunction

    // Append one taken point; a last request closes the round.
    task automatic take_point(input logic rt, input t_point p, input logic lst);
        if (rt == psot_pkg::REQ_SET_A) begin
            if (a_fill >= psot_pkg::MAX_POINTS) begin
                drop_seen = 1'b1;
            end else begin
                set_a_pts[a_fill] = p;
                a_fill++;
            end
        end else begin
            if (b_fill >= psot_pkg::MAX_POINTS) begin
                drop_seen = 1'b1;
            end else begin
                set_b_pts[b_fill] = p;
                b_fill++;
            end
        end
        if (lst) begin
            verdicts_due = {verdicts_due, score_round()};
            a_fill    = 0;
            b_fill    = 0;
            drop_seen = 1'b0;
        end
    endtask

    task automatic check_verdict();
        t_verdict want;
        if (verdicts_due.size() == 0) begin
            $error("result strobe with no round outstanding");
            fail_cnt++;
        end else begin
            want = verdicts_due.pop_front();
            rounds_seen++;
            if (want.overlapped) overlap_seen++;
            if (want.overflow)   drop_rounds++;
            if (o_overlapped !== want.overlapped) begin
                $error("overlapped: expected %0d, got %0d", want.overlapped, o_overlapped);
                fail_cnt++;
            end
            if (o_matched_count !== want.matched) begin
                $error("matched_count: expected %0d, got %0d", want.matched, o_matched_count);
                fail_cnt++;
            end
            if (o_probe_count !== want.probe) begin
                $error("probe_count: expected %0d, got %0d", want.probe, o_probe_count);
                fail_cnt++;
            end
            if (o_overflow !== want.overflow) begin
                $error("overflow: expected %0d, got %0d", want.overflow, o_overflow);
                fail_cnt++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: falling edge. A request stays up until taken; while start is
    // low the payload carries junk the block has to ignore.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        start_nx = start;
        if (i_rst_n && (!start || req_taken)) begin
            start_nx = 1'b0;
            if (pending_pts.size() != 0 && idle_run >= pending_pts[0].gap) begin
                drv_req    = pending_pts.pop_front();
                i_req_type <= drv_req.req_type;
                i_x_coord  <= drv_req.pt.x;
                i_y_coord  <= drv_req.pt.y;
                i_z_coord  <= drv_req.pt.z;
                i_last     <= drv_req.last;
                start_nx   = 1'b1;
                idle_run   = 0;
            end else begin
                if (pending_pts.size() != 0)
                    idle_run++;
                junk       = {$urandom, $urandom, $urandom};
                i_req_type <= junk[72];
                i_x_coord  <= junk[psot_pkg::COORD_BITS-1:0];
                i_y_coord  <= junk[32+psot_pkg::COORD_BITS-1:32];
                i_z_coord  <= junk[64+psot_pkg::COORD_BITS-1:64];
                i_last     <= junk[73];
            end
        end
        start <= start_nx;
    end

    // ------------------------------------------------------------------
    // Monitor: rising edge. Check the result first, then account for a
    // request taken at the same edge (it can only start a new round).
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        req_taken <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                check_verdict();
            end else if (o_valid !== 1'b0) begin
                $error("o_valid unknown after reset");
                fail_cnt++;
            end
            if (start && !busy) begin
                take_point(i_req_type, {i_x_coord, i_y_coord, i_z_coord}, i_last);
                pts_taken++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap(input bit burst);
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(30, 200);
    endfunction

    function automatic int jitter(input int spread);
        return int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    task automatic push_pt(input logic rt, input int x, input int y, input int z,
                           input logic lst, input int gap);
        t_point_req r;
        r.req_type = rt;
        r.pt.x     = x[psot_pkg::COORD_BITS-1:0];
        r.pt.y     = y[psot_pkg::COORD_BITS-1:0];
        r.pt.z     = z[psot_pkg::COORD_BITS-1:0];
        r.last     = lst;
        r.gap      = gap;
        pending_pts = {pending_pts, r};
        pts_queued++;
    endtask

    // One well-formed round: points around a random center, A and B requests
    // interleaved at random, last on the final one. spread < 0 means fully
    // random coordinates; otherwise one point in ten is noise anyway.
    task automatic queue_round(input int na, input int nb, input int spread,
                               input bit burst);
        int   left_a, left_b, cx, cy, cz;
        logic rt;
        left_a = na;
        left_b = nb;
        cx     = $urandom;
        cy     = $urandom;
        cz     = $urandom;
        while (left_a + left_b > 0) begin
            if (left_b == 0)
                rt = psot_pkg::REQ_SET_A;
            else if (left_a == 0)
                rt = psot_pkg::REQ_SET_B;
            else
                rt = ($urandom_range(1, left_a + left_b) <= left_a) ? psot_pkg::REQ_SET_A
                                                                    : psot_pkg::REQ_SET_B;
            if (rt == psot_pkg::REQ_SET_A) left_a--;
            else                           left_b--;
            if (spread < 0 || $urandom_range(0, 9) == 0)
                push_pt(rt, $urandom, $urandom, $urandom, left_a + left_b == 0,
                        pick_gap(burst));
            else
                push_pt(rt, cx + jitter(spread), cy + jitter(spread), cz + jitter(spread),
                        left_a + left_b == 0, pick_gap(burst));
        end
    endtask

    // Register write on the plain port; only called while the block is idle,
    // so the shadow copy can follow at once.
    task automatic write_reg(input logic [psot_pkg::CFG_IDX_W-1:0] idx,
                             input logic [psot_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == psot_pkg::REG_RADIUS)
            radius_cfg = val[psot_pkg::RADIUS_W-1:0];
        else
            ratio_cfg = val[psot_pkg::RATIO_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every queued request is taken and every round answered.
    // Each phase ends on a last request, so the block is idle after that;
    // a few spare cycles before touching the registers.
    task automatic settle();
        while (pts_taken != pts_queued || verdicts_due.size() != 0 || busy !== 1'b0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin : sequencer
        int          phase_pts, na, nb, spread;
        logic [63:0] r64;
        logic [15:0] r16;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed, reset register values (radius^2 94249, ratio ~0.8) ---
        push_pt(psot_pkg::REQ_SET_A, 0, 0, 0, 1'b1, pick_gap(0));   // only A: probe B empty
        push_pt(psot_pkg::REQ_SET_B, 0, 0, 0, 1'b1, pick_gap(0));   // only B: probe A empty
        push_pt(psot_pkg::REQ_SET_A, 0, 0, 0, 1'b0, pick_gap(0));   // tie, B is reference
        push_pt(psot_pkg::REQ_SET_B, 100, 100, 100, 1'b1, pick_gap(0));
        push_pt(psot_pkg::REQ_SET_A, 8388607, -8388608, 8388607, 1'b0, pick_gap(0));
        push_pt(psot_pkg::REQ_SET_A, 0, 0, 0, 1'b0, pick_gap(0));   // A larger: reference
        push_pt(psot_pkg::REQ_SET_B, 300, 0, 0, 1'b1, pick_gap(0));
        push_pt(psot_pkg::REQ_SET_A, 0, 0, 0, 1'b0, pick_gap(0));   // exactly on the radius
        push_pt(psot_pkg::REQ_SET_B, 307, 0, 0, 1'b1, pick_gap(0));
        push_pt(psot_pkg::REQ_SET_B, 0, 0, 0, 1'b0, pick_gap(0));   // one unit beyond it
        push_pt(psot_pkg::REQ_SET_A, 0, 0, 308, 1'b1, pick_gap(0));
        settle();

        // --- zero radius, zero ratio: only identical points match ---
        write_reg(psot_pkg::REG_RADIUS, '0);
        write_reg(psot_pkg::REG_RATIO, '0);
        push_pt(psot_pkg::REQ_SET_A, -8388608, -8388608, -8388608, 1'b0, pick_gap(0));
        push_pt(psot_pkg::REQ_SET_B, -8388608, -8388608, -8388608, 1'b1, pick_gap(0));
        push_pt(psot_pkg::REQ_SET_B, 5, 5, 5, 1'b0, pick_gap(0));
        push_pt(psot_pkg::REQ_SET_A, 5, 5, 6, 1'b1, pick_gap(0));   // 0 > 0 is false
        settle();

        // --- both registers at full scale; upper data bits set on the ratio write ---
        write_reg(psot_pkg::REG_RADIUS, {psot_pkg::CFG_DATA_W{1'b1}});
        write_reg(psot_pkg::REG_RATIO, {psot_pkg::CFG_DATA_W{1'b1}});
        push_pt(psot_pkg::REQ_SET_A, 8388607, 8388607, 8388607, 1'b0, pick_gap(0));
        push_pt(psot_pkg::REQ_SET_B, -8388608, -8388608, -8388608, 1'b1, pick_gap(0));
        push_pt(psot_pkg::REQ_SET_A, 8388607, 0, 0, 1'b0, pick_gap(0));   // widest single axis
        push_pt(psot_pkg::REQ_SET_B, -8388608, 0, 0, 1'b1, pick_gap(0));
        push_pt(psot_pkg::REQ_SET_A, 8388607, 8388607, 8388607, 1'b0, pick_gap(0));
        push_pt(psot_pkg::REQ_SET_A, 0, 0, 0, 1'b0, pick_gap(0));
        push_pt(psot_pkg::REQ_SET_B, -8388608, -8388608, -8388608, 1'b0, pick_gap(0));
        push_pt(psot_pkg::REQ_SET_B, 1, 1, 1, 1'b0, pick_gap(0));
        push_pt(psot_pkg::REQ_SET_B, -8388608, 8388607, -8388608, 1'b1, pick_gap(0));
        settle();

        // --- set A filled to capacity with a few B probes mixed in; the
        //     dropped last still closes the round. Tight cluster so every
        //     probe hits reference point 0. ---
        write_reg(psot_pkg::REG_RADIUS,
                  {{(psot_pkg::CFG_DATA_W-psot_pkg::RADIUS_W){1'b0}}, psot_pkg::RADIUS_RESET});
        write_reg(psot_pkg::REG_RATIO,
                  {{(psot_pkg::CFG_DATA_W-psot_pkg::RATIO_W){1'b0}}, psot_pkg::RATIO_RESET});
        for (int i = 0; i < psot_pkg::MAX_POINTS; i++) begin
            push_pt(psot_pkg::REQ_SET_A, jitter(50), jitter(50), jitter(50), 1'b0, 0);
            if (i % 170 == 3)
                push_pt(psot_pkg::REQ_SET_B, jitter(50), jitter(50), jitter(50), 1'b0, 0);
        end
        push_pt(psot_pkg::REQ_SET_A, 0, 0, 0, 1'b1, 0);                  // dropped last
        push_pt(psot_pkg::REQ_SET_B, 0, 0, 0, 1'b1, pick_gap(0));        // drop flag clear
        settle();

        // --- random rounds under six register settings ---
        for (int p = 0; p < 6; p++) begin
            r64 = {$urandom, $urandom};
            r16 = r64[15:0];
            case (p)
                0: write_reg(psot_pkg::REG_RADIUS,
                             {{(psot_pkg::CFG_DATA_W-psot_pkg::RADIUS_W){1'b0}},
                              psot_pkg::RADIUS_RESET});
                1: write_reg(psot_pkg::REG_RADIUS,
                             psot_pkg::CFG_DATA_W'($urandom_range(0, 2000)));
                2: write_reg(psot_pkg::REG_RADIUS, r64[psot_pkg::CFG_DATA_W-1:0]);
                3: write_reg(psot_pkg::REG_RADIUS, {8'd0, r64[39:0]} >> $urandom_range(0, 30));
                4: write_reg(psot_pkg::REG_RADIUS, '0);
                default: write_reg(psot_pkg::REG_RADIUS, {psot_pkg::CFG_DATA_W{1'b1}});
            endcase
            case (p)
                1: write_reg(psot_pkg::REG_RATIO, '0);
                2: write_reg(psot_pkg::REG_RATIO,
                             {{(psot_pkg::CFG_DATA_W-psot_pkg::RATIO_W){1'b0}}, 16'hFFFF});
                default: write_reg(psot_pkg::REG_RATIO, {r64[63:48], r64[63:48], r16});
            endcase
            phase_pts = 0;
            while (phase_pts < 20) begin
                if ($urandom_range(0, 99) < 85) begin
                    na = $urandom_range(0, 5);
                    nb = $urandom_range(0, 5);
                end else begin
                    na = $urandom_range(0, 16);
                    nb = $urandom_range(0, 16);
                end
                if (na + nb == 0)
                    na = 1;
                case ($urandom_range(0, 6))
                    0: spread = 0;
                    1: spread = 2;
                    2: spread = 40;
                    3: spread = 300;
                    4: spread = 5000;
                    5: spread = 1 << 21;
                    default: spread = -1;
                endcase
                queue_round(na, nb, spread, $urandom_range(0, 4) == 0);
                phase_pts += na + nb;
            end
            settle();
        end

        repeat (20) @(negedge i_clk);
        if (verdicts_due.size() != 0) begin
            $error("%0d rounds never answered", verdicts_due.size());
            fail_cnt++;
        end
        $display("Run covered %0d rounds from %0d point requests across several settings:",
                 rounds_seen, pts_taken);
        $display("  %0d rounds reported overlap, %0d rounds had dropped points",
                 overlap_seen, drop_rounds);
        if (fail_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hard stop: far beyond the slowest legal run (long gaps on every request
    // plus the exhaustive search of every round).
    initial begin
        #20000000;
        $display("Timeout: block stopped answering");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
rtl/psot_pkg.sv
rtl/psot_ram.sv
rtl/psot_dist.sv
rtl/point_set_overlap_test.sv
bench/tb_point_set_overlap_test.sv
